// ===== rtl/cdes_pkg.sv =====
package cdes_pkg;

	// Pipeline depth: one valid bit and one register set for each stage.
	localparam int unsigned NUM_STAGES = 7;

	// Field widths.
	localparam int unsigned YEAR_W = 16;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned EPOCH_W = 32;

	// Internal widths, sized to the ranges that the arithmetic can reach.
	localparam int unsigned YPROD_W = 34;
	localparam int unsigned ERA_W = 8;
	localparam int unsigned YOE_W = 9;
	localparam int unsigned MPROD_W = 16;
	localparam int unsigned MQ_W = 32;
	localparam int unsigned DOY_W = 14;
	localparam int unsigned TOD_W = 20;
	localparam int unsigned MIN60_W = 14;
	localparam int unsigned YTERM_W = 18;
	localparam int unsigned YCENT_W = 15;
	localparam int unsigned DAYS_W = 27;
	localparam int unsigned SECS_W = 43;

	// Months up to February belong to the previous March-based year.
	localparam logic [BYTE_W-1:0] LAST_SHIFTED_MONTH = 8'd2;
	localparam logic [BYTE_W-1:0] MONTH_WRAP_ADD = 8'd9;
	localparam logic [BYTE_W-1:0] MONTH_SHIFT_SUB = 8'd3;

	// Month start: (153 * index + 2) / 5, the division done by reciprocal.
	localparam logic [MPROD_W-1:0] MONTH_MUL = 16'd153;
	localparam logic [MPROD_W-1:0] MONTH_BIAS = 16'd2;
	localparam logic [MQ_W-1:0] DIV5_RECIP = 32'd52429;
	localparam int unsigned DIV5_SHIFT = 18;

	// Era: year / 400 by reciprocal, exact for every 16-bit year.
	localparam logic [YPROD_W-1:0] ERA_RECIP = 34'd167773;
	localparam int unsigned ERA_SHIFT = 26;
	localparam logic [YEAR_W-1:0] YEARS_PER_ERA = 16'd400;
	localparam logic [YOE_W-1:0] LAST_YEAR_OF_ERA = 9'd399;

	// Day of era terms; year of era / 100 by reciprocal, exact for every 9-bit value.
	localparam logic [YTERM_W-1:0] DAYS_PER_YEAR = 18'd365;
	localparam logic [YCENT_W-1:0] CENT_RECIP = 15'd41;
	localparam int unsigned CENT_SHIFT = 12;

	localparam logic signed [DAYS_W-1:0] DAYS_PER_ERA = 27'sd146097;
	localparam logic signed [DAYS_W-1:0] DAYS_TO_EPOCH = 27'sd719468;

	localparam logic [TOD_W-1:0] SECONDS_PER_HOUR = 20'd3600;
	localparam logic [MIN60_W-1:0] SECONDS_PER_MINUTE = 14'd60;
	localparam logic signed [SECS_W-1:0] SECONDS_PER_DAY = 43'sd86400;

	typedef logic [NUM_STAGES-1:0] stage_vec_t;

	// Pipeline control handed from the controller to the datapath.
	typedef struct packed {
		stage_vec_t adv;  // stage register loads this cycle
		stage_vec_t vld;  // stage holds a live transaction
	} pipe_ctl_t;

endpackage

// ===== rtl/cdes_time_if.sv =====
interface cdes_time_if;

	logic       valid;
	logic       ready;
	logic [15:0] year_value;
	logic [7:0] month_value;
	logic [7:0] day_value;
	logic [7:0] hour_value;
	logic [7:0] minute_value;
	logic [7:0] second_value;

	modport source (
		output valid, year_value, month_value, day_value,
		output hour_value, minute_value, second_value,
		input  ready
	);

	modport sink (
		input  valid, year_value, month_value, day_value,
		input  hour_value, minute_value, second_value,
		output ready
	);

endinterface

// ===== rtl/cdes_epoch_if.sv =====
interface cdes_epoch_if;

	logic        valid;
	logic        ready;
	logic [31:0] epoch_seconds;

	modport source (
		output valid, epoch_seconds,
		input  ready
	);

	modport sink (
		input  valid, epoch_seconds,
		output ready
	);

endinterface

// ===== rtl/cdes_pipe_ctrl.sv =====
module cdes_pipe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output cdes_pkg::pipe_ctl_t ctl
);

	cdes_pkg::stage_vec_t vld_q;
	cdes_pkg::stage_vec_t adv;

	// A stage may load when it is empty or when the stage after it moves on.
	always_comb begin
		adv[cdes_pkg::NUM_STAGES-1] = !vld_q[cdes_pkg::NUM_STAGES-1] || out_ready;
		for (int k = cdes_pkg::NUM_STAGES - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	// Valid bits travel alongside the data registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < cdes_pkg::NUM_STAGES; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = vld_q[cdes_pkg::NUM_STAGES-1];
	assign ctl.adv   = adv;
	assign ctl.vld   = vld_q;

endmodule

// ===== rtl/cdes_date_split.sv =====
module cdes_date_split (
	input  logic                               clk,
	input  cdes_pkg::pipe_ctl_t                ctl,
	input  logic [cdes_pkg::YEAR_W-1:0]        year_value,
	input  logic [cdes_pkg::BYTE_W-1:0]        month_value,
	input  logic [cdes_pkg::BYTE_W-1:0]        day_value,
	input  logic [cdes_pkg::BYTE_W-1:0]        hour_value,
	input  logic [cdes_pkg::BYTE_W-1:0]        minute_value,
	input  logic [cdes_pkg::BYTE_W-1:0]        second_value,
	output logic signed [cdes_pkg::YOE_W-1:0]  era_s3,
	output logic [cdes_pkg::YOE_W-1:0]         yoe_s3,
	output logic signed [cdes_pkg::DOY_W-1:0]  doy_s3,
	output logic [cdes_pkg::TOD_W-1:0]         tod_s3
);

	logic                               early;
	logic [cdes_pkg::YEAR_W-1:0]        ysh;
	logic [cdes_pkg::BYTE_W-1:0]        idx;

	logic                               neg_s1;
	logic [cdes_pkg::YEAR_W-1:0]        y_s1;
	logic [cdes_pkg::YPROD_W-1:0]       yprod_s1;
	logic [cdes_pkg::MPROD_W-1:0]       mprod_s1;
	logic [cdes_pkg::BYTE_W-1:0]        day_s1;
	logic [cdes_pkg::TOD_W-1:0]         hprod_s1;
	logic [cdes_pkg::MIN60_W-1:0]       min60_s1;
	logic [cdes_pkg::BYTE_W-1:0]        sec_s1;

	logic                               neg_s2;
	logic [cdes_pkg::YEAR_W-1:0]        y_s2;
	logic [cdes_pkg::ERA_W-1:0]         era_s2;
	logic [cdes_pkg::MQ_W-1:0]          mq_s2;
	logic [cdes_pkg::BYTE_W-1:0]        day_s2;
	logic [cdes_pkg::TOD_W-1:0]         tod_s2;

	logic [cdes_pkg::YEAR_W-1:0]        era400;
	logic [cdes_pkg::YEAR_W-1:0]        yoe_full;

	// Shift the year to start in March and pick the month index.
	always_comb begin
		early = (month_value <= cdes_pkg::LAST_SHIFTED_MONTH);
		ysh   = year_value - cdes_pkg::YEAR_W'(early);
		idx   = early ? (month_value + cdes_pkg::MONTH_WRAP_ADD)
		              : (month_value - cdes_pkg::MONTH_SHIFT_SUB);
	end

	// Stage 1: reciprocal product for the era, month product, time-of-day products.
	// A month up to February of year zero lands in era -1; that case is flagged.
	always_ff @(posedge clk) begin
		if (ctl.adv[0]) begin
			neg_s1   <= early && (year_value == '0);
			y_s1     <= ysh;
			yprod_s1 <= cdes_pkg::YPROD_W'(ysh) * cdes_pkg::ERA_RECIP;
			mprod_s1 <= cdes_pkg::MPROD_W'(idx) * cdes_pkg::MONTH_MUL + cdes_pkg::MONTH_BIAS;
			day_s1   <= day_value;
			hprod_s1 <= cdes_pkg::TOD_W'(hour_value) * cdes_pkg::SECONDS_PER_HOUR;
			min60_s1 <= cdes_pkg::MIN60_W'(minute_value) * cdes_pkg::SECONDS_PER_MINUTE;
			sec_s1   <= second_value;
		end
	end

	// Stage 2: era out of the product, divide-by-five product, time of day summed.
	always_ff @(posedge clk) begin
		if (ctl.adv[1]) begin
			neg_s2 <= neg_s1;
			y_s2   <= y_s1;
			era_s2 <= yprod_s1[cdes_pkg::ERA_SHIFT +: cdes_pkg::ERA_W];
			mq_s2  <= cdes_pkg::MQ_W'(mprod_s1) * cdes_pkg::DIV5_RECIP;
			day_s2 <= day_s1;
			tod_s2 <= hprod_s1 + cdes_pkg::TOD_W'(min60_s1) + cdes_pkg::TOD_W'(sec_s1);
		end
	end

	// Year of era is what remains after the whole eras are taken out.
	always_comb begin
		era400   = cdes_pkg::YEAR_W'(era_s2) * cdes_pkg::YEARS_PER_ERA;
		yoe_full = y_s2 - era400;
	end

	// Stage 3: signed era, year of era and day of year (which may be -1).
	always_ff @(posedge clk) begin
		if (ctl.adv[2]) begin
			if (neg_s2) begin
				era_s3 <= -9'sd1;
				yoe_s3 <= cdes_pkg::LAST_YEAR_OF_ERA;
			end else begin
				era_s3 <= signed'(cdes_pkg::YOE_W'(era_s2));
				yoe_s3 <= yoe_full[cdes_pkg::YOE_W-1:0];
			end
			doy_s3 <= signed'(mq_s2[cdes_pkg::DIV5_SHIFT +: cdes_pkg::DOY_W])
			        + signed'(cdes_pkg::DOY_W'(day_s2)) - 14'sd1;
			tod_s3 <= tod_s2;
		end
	end

endmodule

// ===== rtl/cdes_day_count.sv =====
module cdes_day_count (
	input  logic                                clk,
	input  cdes_pkg::pipe_ctl_t                 ctl,
	input  logic signed [cdes_pkg::YOE_W-1:0]   era_s3,
	input  logic [cdes_pkg::YOE_W-1:0]          yoe_s3,
	input  logic signed [cdes_pkg::DOY_W-1:0]   doy_s3,
	input  logic [cdes_pkg::TOD_W-1:0]          tod_s3,
	output logic signed [cdes_pkg::DAYS_W-1:0]  days_s5,
	output logic [cdes_pkg::TOD_W-1:0]          tod_s5
);

	logic signed [cdes_pkg::DAYS_W-1:0] era_x;

	logic signed [cdes_pkg::DAYS_W-1:0] eraday_s4;
	logic [cdes_pkg::YTERM_W-1:0]       yterm_s4;
	logic [cdes_pkg::YCENT_W-1:0]       ycent_s4;
	logic signed [cdes_pkg::DOY_W-1:0]  doy_s4;
	logic [cdes_pkg::TOD_W-1:0]         tod_s4;

	logic signed [cdes_pkg::DAYS_W-1:0] yterm_x;
	logic signed [cdes_pkg::DAYS_W-1:0] ycent_x;
	logic signed [cdes_pkg::DAYS_W-1:0] doy_x;

	assign era_x = cdes_pkg::DAYS_W'(era_s3);

	// Stage 4: days of whole eras, year-of-era days with leap years every fourth,
	// and the product whose top bits give the dropped century leap days.
	always_ff @(posedge clk) begin
		if (ctl.adv[3]) begin
			eraday_s4 <= era_x * cdes_pkg::DAYS_PER_ERA;
			yterm_s4  <= cdes_pkg::YTERM_W'(yoe_s3) * cdes_pkg::DAYS_PER_YEAR
			           + cdes_pkg::YTERM_W'(yoe_s3 >> 2);
			ycent_s4  <= cdes_pkg::YCENT_W'(yoe_s3) * cdes_pkg::CENT_RECIP;
			doy_s4    <= doy_s3;
			tod_s4    <= tod_s3;
		end
	end

	// Bring every term to the signed day width.
	always_comb begin
		yterm_x = signed'(cdes_pkg::DAYS_W'(yterm_s4));
		ycent_x = signed'(cdes_pkg::DAYS_W'(ycent_s4[cdes_pkg::YCENT_W-1:cdes_pkg::CENT_SHIFT]));
		doy_x   = cdes_pkg::DAYS_W'(doy_s4);
	end

	// Stage 5: days relative to the first of January 1970.
	always_ff @(posedge clk) begin
		if (ctl.adv[4]) begin
			days_s5 <= eraday_s4 + yterm_x - ycent_x + doy_x - cdes_pkg::DAYS_TO_EPOCH;
			tod_s5  <= tod_s4;
		end
	end

endmodule

// ===== rtl/cdes_sec_scale.sv =====
module cdes_sec_scale (
	input  logic                               clk,
	input  cdes_pkg::pipe_ctl_t                ctl,
	input  logic signed [cdes_pkg::DAYS_W-1:0] days_s5,
	input  logic [cdes_pkg::TOD_W-1:0]         tod_s5,
	output logic [cdes_pkg::EPOCH_W-1:0]       epoch_s7
);

	logic signed [cdes_pkg::SECS_W-1:0] days_x;
	logic signed [cdes_pkg::SECS_W-1:0] dprod_s6;
	logic [cdes_pkg::TOD_W-1:0]         tod_s6;
	logic signed [cdes_pkg::SECS_W-1:0] total;

	assign days_x = cdes_pkg::SECS_W'(days_s5);

	// Stage 6: days scaled to seconds.
	always_ff @(posedge clk) begin
		if (ctl.adv[5]) begin
			dprod_s6 <= days_x * cdes_pkg::SECONDS_PER_DAY;
			tod_s6   <= tod_s5;
		end
	end

	assign total = dprod_s6 + signed'(cdes_pkg::SECS_W'(tod_s6));

	// Stage 7: a negative total or one beyond 32 bits shows a set upper bit,
	// and then the result is zero.
	always_ff @(posedge clk) begin
		if (ctl.adv[6]) begin
			epoch_s7 <= (|total[cdes_pkg::SECS_W-1:cdes_pkg::EPOCH_W]) ? '0
			          : total[cdes_pkg::EPOCH_W-1:0];
		end
	end

endmodule

// ===== rtl/civil_datetime_to_epoch_seconds_core.sv =====
// Converts a UTC calendar date and time (proleptic Gregorian, no range checks on
// any field) into seconds since 1970-01-01 00:00:00; a total below zero or above
// 32 bits gives 0. The datapath is a seven-stage register pipeline: a transaction
// accepted at the input passes every stage register before it is offered as a
// result; a new transaction can be accepted on every cycle unless the pipe stalls.
// When the result is not taken, the run of full stages next to the output holds
// while any empty stage behind it keeps filling, so input ready drops only once all
// seven stages carry a transaction and the result is still not taken.
module civil_datetime_to_epoch_seconds_core (
	input  logic        clk,
	input  logic        arst_n,
	cdes_time_if.sink   civil,
	cdes_epoch_if.source epoch
);

	cdes_pkg::pipe_ctl_t ctl;

	logic signed [cdes_pkg::YOE_W-1:0]  era_s3;
	logic [cdes_pkg::YOE_W-1:0]         yoe_s3;
	logic signed [cdes_pkg::DOY_W-1:0]  doy_s3;
	logic [cdes_pkg::TOD_W-1:0]         tod_s3;
	logic signed [cdes_pkg::DAYS_W-1:0] days_s5;
	logic [cdes_pkg::TOD_W-1:0]         tod_s5;
	logic [cdes_pkg::EPOCH_W-1:0]       epoch_s7;

	// Valid bits and stage loads.
	cdes_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (civil.valid),
		.in_ready  (civil.ready),
		.out_valid (epoch.valid),
		.out_ready (epoch.ready),
		.ctl       (ctl)
	);

	// Era, year of era, day of year and time of day.
	cdes_date_split u_split (
		.clk          (clk),
		.ctl          (ctl),
		.year_value   (civil.year_value),
		.month_value  (civil.month_value),
		.day_value    (civil.day_value),
		.hour_value   (civil.hour_value),
		.minute_value (civil.minute_value),
		.second_value (civil.second_value),
		.era_s3       (era_s3),
		.yoe_s3       (yoe_s3),
		.doy_s3       (doy_s3),
		.tod_s3       (tod_s3)
	);

	// Day count relative to the epoch.
	cdes_day_count u_days (
		.clk     (clk),
		.ctl     (ctl),
		.era_s3  (era_s3),
		.yoe_s3  (yoe_s3),
		.doy_s3  (doy_s3),
		.tod_s3  (tod_s3),
		.days_s5 (days_s5),
		.tod_s5  (tod_s5)
	);

	// Seconds, and a zero result for a total outside 32 bits.
	cdes_sec_scale u_secs (
		.clk      (clk),
		.ctl      (ctl),
		.days_s5  (days_s5),
		.tod_s5   (tod_s5),
		.epoch_s7 (epoch_s7)
	);

	assign epoch.epoch_seconds = epoch_s7;

`ifndef ASSERT_OFF
	// With the output stage free to move, the pipeline must take a new transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!epoch.valid || epoch.ready) |-> civil.ready)
		else $error("input stalled although the output stage can advance");

	// A full pipeline facing a stalled output must refuse input.
	assert property (@(posedge clk) disable iff (!arst_n)
		((&ctl.vld) && !epoch.ready) |-> !civil.ready)
		else $error("input accepted into a full, stalled pipeline");

	// An accepted transaction occupies the first stage on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(civil.valid && civil.ready) |=> ctl.vld[0])
		else $error("accepted transaction missing from the first stage");

	// A result only appears after the stage before the output held a transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(epoch.valid) |-> $past(ctl.vld[cdes_pkg::NUM_STAGES-2]))
		else $error("result appeared without a transaction behind it");
`endif

endmodule

// ===== dv/testbench.sv =====
module testbench;

	// One calendar date and time as it enters the block.
	typedef struct packed {
		logic [cdes_pkg::YEAR_W-1:0] year;
		logic [cdes_pkg::BYTE_W-1:0] month;
		logic [cdes_pkg::BYTE_W-1:0] day;
		logic [cdes_pkg::BYTE_W-1:0] hour;
		logic [cdes_pkg::BYTE_W-1:0] minute;
		logic [cdes_pkg::BYTE_W-1:0] sec;
	} datetime_t;

	// A predicted result, kept with the date that produced it for reporting.
	typedef struct {
		datetime_t stamp;
		logic [cdes_pkg::EPOCH_W-1:0] secs;
	} epoch_expect_t;

	localparam longint EPOCH_MAX = (longint'(1) << cdes_pkg::EPOCH_W) - 1;
	localparam int IDLE_LIMIT = 3000;

	logic clk;
	logic arst_n;

	cdes_time_if civil_if ();
	cdes_epoch_if epoch_if ();

	civil_datetime_to_epoch_seconds_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.civil  (civil_if),
		.epoch  (epoch_if)
	);

	epoch_expect_t expected_epochs[$];
	int unsigned error_count = 0;
	int unsigned items_accepted = 0;
	int unsigned results_checked = 0;
	int unsigned zero_results = 0;
	int unsigned idle_cycles = 0;
	int unsigned input_stall_cycles = 0;
	bit source_idles = 1'b0;
	bit sink_idles = 1'b0;
	int hold_request = 0;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Expected seconds since the epoch, by the era-based day count with March
	// as the first month of the year.
	function automatic logic [cdes_pkg::EPOCH_W-1:0] predict_epoch(input datetime_t t);
		longint yr, mo, dy, shifted_year, era, year_of_era, month_index;
		longint day_of_year, day_of_era, day_count, total;
		yr = t.year;
		mo = t.month;
		dy = t.day;
		shifted_year = yr - ((mo <= 2) ? 1 : 0);
		era = (shifted_year >= 0) ? shifted_year / 400 : -1;
		year_of_era = shifted_year - era * 400;
		month_index = (mo > 2) ? mo - 3 : mo + 9;
		day_of_year = (153 * month_index + 2) / 5 + dy - 1;
		day_of_era = year_of_era * 365 + year_of_era / 4 - year_of_era / 100 + day_of_year;
		day_count = era * 146097 + day_of_era - 719468;
		total = day_count * 86400 + longint'(t.hour) * 3600 + longint'(t.minute) * 60
			+ longint'(t.sec);
		if (total < 0 || total > EPOCH_MAX)
			return '0;
		return total[cdes_pkg::EPOCH_W-1:0];
	endfunction

	function automatic datetime_t stamp(input int y, input int mo, input int d,
			input int h, input int mi, input int s);
		datetime_t t;
		t.year = y[cdes_pkg::YEAR_W-1:0];
		t.month = mo[cdes_pkg::BYTE_W-1:0];
		t.day = d[cdes_pkg::BYTE_W-1:0];
		t.hour = h[cdes_pkg::BYTE_W-1:0];
		t.minute = mi[cdes_pkg::BYTE_W-1:0];
		t.sec = s[cdes_pkg::BYTE_W-1:0];
		return t;
	endfunction

	// Idle length: mostly a few cycles, now and then a long one.
	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// A sensible date between the epoch and the 32-bit limit, or a bit outside that range.
	function automatic datetime_t random_plausible();
		int y;
		y = ($urandom_range(0, 9) < 8) ? $urandom_range(1970, 2106) : $urandom_range(1900, 2200);
		return stamp(y, $urandom_range(1, 12), $urandom_range(1, 31), $urandom_range(0, 23),
			$urandom_range(0, 59), $urandom_range(0, 59));
	endfunction

	// Every field across its full width.
	function automatic datetime_t random_any();
		return stamp($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
	endfunction

	// Fields drawn from values around the era, epoch and month boundaries.
	function automatic datetime_t random_boundary();
		int years[12] = '{0, 1, 2, 399, 400, 401, 1969, 1970, 2000, 2105, 2106, 65535};
		int months[8] = '{0, 1, 2, 3, 11, 12, 13, 255};
		int days[7] = '{0, 1, 7, 28, 29, 31, 255};
		int hours[5] = '{0, 6, 23, 24, 255};
		int sixties[5] = '{0, 28, 59, 60, 255};
		return stamp(years[$urandom_range(0, 11)], months[$urandom_range(0, 7)],
			days[$urandom_range(0, 6)], hours[$urandom_range(0, 4)],
			sixties[$urandom_range(0, 4)], sixties[$urandom_range(0, 4)]);
	endfunction

	// Offers one date, sometimes idling first when source idling is on, and returns on
	// the edge at which the transaction is taken.
	task automatic send_datetime(input datetime_t t);
		int gap;
		datetime_t junk;
		gap = (source_idles && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
		repeat (gap) begin
			@(negedge clk);
			junk = random_any();
			civil_if.valid <= 1'b0;
			civil_if.year_value <= junk.year;
			civil_if.month_value <= junk.month;
			civil_if.day_value <= junk.day;
			civil_if.hour_value <= junk.hour;
			civil_if.minute_value <= junk.minute;
			civil_if.second_value <= junk.sec;
		end
		@(negedge clk);
		civil_if.valid <= 1'b1;
		civil_if.year_value <= t.year;
		civil_if.month_value <= t.month;
		civil_if.day_value <= t.day;
		civil_if.hour_value <= t.hour;
		civil_if.minute_value <= t.minute;
		civil_if.second_value <= t.sec;
		do
			@(posedge clk);
		while (civil_if.ready !== 1'b1);
	endtask

	// Withdraws the last offer, then waits until every prediction is matched.
	task automatic wait_for_results();
		@(negedge clk);
		civil_if.valid <= 1'b0;
		while (expected_epochs.size() != 0)
			@(posedge clk);
	endtask

	// Field extremes, the epoch, the 32-bit limits and each odd corner of the
	// day count.
	task automatic test_directed();
		source_idles = 1'b0;
		sink_idles = 1'b0;
		send_datetime(stamp(1970, 1, 1, 0, 0, 0));
		send_datetime(stamp(1970, 1, 1, 0, 0, 1));
		send_datetime(stamp(1969, 12, 31, 23, 59, 59));
		send_datetime(stamp(2000, 2, 29, 12, 34, 56));
		send_datetime(stamp(2100, 2, 29, 0, 0, 0));
		send_datetime(stamp(2038, 1, 19, 3, 14, 7));
		send_datetime(stamp(2106, 2, 7, 6, 28, 15));
		send_datetime(stamp(2106, 2, 7, 6, 28, 16));
		send_datetime(stamp(0, 0, 0, 0, 0, 0));
		send_datetime(stamp(0, 1, 1, 0, 0, 0));
		send_datetime(stamp(0, 2, 29, 23, 59, 59));
		send_datetime(stamp(0, 3, 1, 0, 0, 0));
		send_datetime(stamp(2000, 3, 0, 0, 0, 0));
		send_datetime(stamp(1970, 3, 0, 12, 0, 0));
		send_datetime(stamp(1970, 1, 0, 255, 0, 0));
		send_datetime(stamp(1970, 0, 31, 0, 0, 0));
		send_datetime(stamp(1975, 255, 255, 255, 255, 255));
		send_datetime(stamp(2000, 13, 40, 24, 60, 60));
		send_datetime(stamp(1980, 6, 15, 0, 255, 255));
		send_datetime(stamp(65535, 255, 255, 255, 255, 255));
		send_datetime(stamp(65535, 0, 0, 0, 0, 0));
		send_datetime(stamp(2400, 2, 29, 0, 0, 0));
		wait_for_results();
	endtask

	// Mostly sensible dates, with boundary values and raw noise mixed in,
	// under random idling on both sides.
	task automatic test_random_mix(input int count);
		int pick;
		source_idles = 1'b1;
		sink_idles = 1'b1;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 60)
				send_datetime(random_plausible());
			else if (pick < 80)
				send_datetime(random_any());
			else
				send_datetime(random_boundary());
		end
	endtask

	// The receiver holds off for a long stretch while dates keep coming, so
	// the pipeline fills and input ready drops.
	task automatic test_output_backpressure(input int count);
		source_idles = 1'b0;
		sink_idles = 1'b0;
		hold_request = 80;
		for (int i = 0; i < count; i++)
			send_datetime(($urandom_range(0, 1) != 0) ? random_plausible() : random_any());
		wait_for_results();
	endtask

	// The sender stops until every result is out, then starts again.
	task automatic test_drain_pause(input int count);
		source_idles = 1'b1;
		sink_idles = 1'b1;
		for (int i = 0; i < count; i++)
			send_datetime(random_plausible());
		wait_for_results();
		for (int i = 0; i < count; i++)
			send_datetime(random_boundary());
	endtask

	// Full rate on both sides with no idling at all.
	task automatic test_back_to_back(input int count);
		source_idles = 1'b0;
		sink_idles = 1'b0;
		for (int i = 0; i < count; i++)
			send_datetime(($urandom_range(0, 3) != 0) ? random_plausible() : random_any());
	endtask

	// Receiver: a long hold-off on request, otherwise random stalls when enabled.
	initial begin
		int hold_left;
		int gap_left;
		hold_left = 0;
		gap_left = 0;
		epoch_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				epoch_if.ready <= 1'b0;
				hold_left--;
			end else if (gap_left > 0) begin
				epoch_if.ready <= 1'b0;
				gap_left--;
			end else if (sink_idles && $urandom_range(0, 99) < 25) begin
				gap_left = pick_gap() - 1;
				epoch_if.ready <= 1'b0;
			end else begin
				epoch_if.ready <= 1'b1;
			end
		end
	end

	// Records each accepted date with its prediction, checks each result
	// against the oldest prediction and watches for a stuck handshake.
	always @(posedge clk) begin
		epoch_expect_t want;
		datetime_t seen;
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (civil_if.valid === 1'b1 && civil_if.ready === 1'b1) begin
				seen.year = civil_if.year_value;
				seen.month = civil_if.month_value;
				seen.day = civil_if.day_value;
				seen.hour = civil_if.hour_value;
				seen.minute = civil_if.minute_value;
				seen.sec = civil_if.second_value;
				want.stamp = seen;
				want.secs = predict_epoch(seen);
				expected_epochs.insert(expected_epochs.size(), want);
				items_accepted++;
				moved = 1'b1;
			end else if (civil_if.valid === 1'b1) begin
				input_stall_cycles++;
			end
			if (epoch_if.valid === 1'b1 && epoch_if.ready === 1'b1) begin
				moved = 1'b1;
				results_checked++;
				if (epoch_if.epoch_seconds == '0)
					zero_results++;
				if (expected_epochs.size() == 0) begin
					error_count++;
					$display("%0t: unexpected transaction: expected none, actual %0d",
						$time, epoch_if.epoch_seconds);
				end else begin
					want = expected_epochs.pop_front();
					if (epoch_if.epoch_seconds !== want.secs) begin
						error_count++;
						$display("%0t: epoch_seconds for %0d-%0d-%0d %0d:%0d:%0d: expected %0d, actual %0d",
							$time, want.stamp.year, want.stamp.month, want.stamp.day,
							want.stamp.hour, want.stamp.minute, want.stamp.sec,
							want.secs, epoch_if.epoch_seconds);
					end
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d results outstanding",
					$time, IDLE_LIMIT, expected_epochs.size());
				$display("status: fail");
				$finish;
			end
		end
	end

	// Test sequence.
	initial begin
		arst_n = 1'b0;
		civil_if.valid = 1'b0;
		civil_if.year_value = '0;
		civil_if.month_value = '0;
		civil_if.day_value = '0;
		civil_if.hour_value = '0;
		civil_if.minute_value = '0;
		civil_if.second_value = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_mix(800);
		test_output_backpressure(150);
		test_drain_pause(60);
		test_back_to_back(160);
		test_random_mix(700);

		@(negedge clk);
		civil_if.valid <= 1'b0;
		wait_for_results();
		repeat (cdes_pkg::NUM_STAGES + 4) @(posedge clk);

		$display("Sent %0d dates and checked %0d results, %0d of them zero (before the epoch or past 32 bits).",
			items_accepted, results_checked, zero_results);
		$display("Input was held off for %0d cycles by output back-pressure; %0d errors.",
			input_stall_cycles, error_count);
		if (error_count == 0 && expected_epochs.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
